>>> rtl/core/lbp_pkg.sv
// lbp_pkg: shared widths, types and the pattern function of the 3x3 lbp stream
// no dependencies; imported by lbp_scan, lbp_window, lbp_3x3_stream and lbp_chk

package lbp_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int WCFG_W      = 11;
    localparam int HCFG_W      = 12;
    localparam int PIX_W       = 8;
    localparam int CODE_W      = 8;
    localparam int LINE_W      = 2 * PIX_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int OUT_FLD_W   = CODE_W + ROW_W + COL_W;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] pix_t;

    // w[row][col], row 0 above, col 0 left, centre at w[1][1]
    typedef pix_t [2:0][2:0] window_t;

    // which of the up to four codes a pixel releases
    typedef enum logic [1:0] {
        RES_UP_LEFT   = 2'd0,
        RES_UP        = 2'd1,
        RES_LEFT      = 2'd2,
        RES_HERE      = 2'd3
    } res_kind_t;

    // position of the accepted pixel and its edge flags
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             r_ge1;
        logic             r_ge2;
        logic             c_ge1;
        logic             c_ge2;
        logic             c_last;
        logic             r_last;
    } scan_info_t;

    function automatic logic [CODE_W-1:0] lbp_pattern(
        input window_t w,
        input logic    top,
        input logic    bot,
        input logic    left,
        input logic    right
    );
        logic [CODE_W-1:0] code;
        pix_t              cen;
        cen     = w[1][1];
        code[0] = top && left  && (w[0][0] >= cen);
        code[1] = top          && (w[0][1] >= cen);
        code[2] = top && right && (w[0][2] >= cen);
        code[3] = right        && (w[1][2] >= cen);
        code[4] = bot && right && (w[2][2] >= cen);
        code[5] = bot          && (w[2][1] >= cen);
        code[6] = bot && left  && (w[2][0] >= cen);
        code[7] = left         && (w[1][0] >= cen);
        return code;
    endfunction

endpackage

>>> rtl/core/lbp_ram.sv
// lbp_ram: simple dual-port synchronous ram, registered read
// no dependencies; a write to the address being read is passed straight to the read data

module lbp_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lbp_scan.sv
// lbp_scan: configuration registers and the raster row/column counters
// depends on lbp_pkg

module lbp_scan
    import lbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    output scan_info_t            info,
    output logic                  restart
);

    logic [WCFG_W-1:0] width_reg, width_next;
    logic [HCFG_W-1:0] height_reg, height_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;

    logic              cfg_fire;
    logic [WCFG_W-1:0] width_m1;
    logic [HCFG_W-1:0] height_m1;
    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign restart   = cfg_fire && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

    // zero width acts as one, widths above the line buffer saturate
    always_comb
    begin
        width_m1  = width_reg - WCFG_W'(1);
        height_m1 = height_reg - HCFG_W'(1);
        if (width_reg == '0)
        begin
            last_col = '0;
        end
        else if (width_reg > WCFG_W'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = width_m1[COL_W-1:0];
        end
        if (height_reg == '0)
        begin
            last_row = '0;
        end
        else
        begin
            last_row = ROW_W'(height_m1);
        end
    end

    always_comb
    begin
        info.row    = row_reg;
        info.col    = col_reg;
        info.r_ge1  = (row_reg != '0);
        info.r_ge2  = (row_reg > ROW_W'(1));
        info.c_ge1  = (col_reg != '0);
        info.c_ge2  = (col_reg > COL_W'(1));
        info.c_last = (col_reg == last_col);
        info.r_last = (row_reg == last_row);
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        if (accept)
        begin
            if (info.c_last)
            begin
                col_next = '0;
                row_next = info.r_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (cfg_fire)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                width_next = cfg_data[WCFG_W-1:0];
            end
            if (cfg_index == REG_HEIGHT)
            begin
                height_next = cfg_data[HCFG_W-1:0];
            end
        end
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

endmodule

>>> rtl/core/lbp_window.sv
// lbp_window: 3x3 window, code sequencing and the output register
// depends on lbp_pkg; line-buffer data comes from lbp_ram

module lbp_window
    import lbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  pix_t                   pixel,
    input  scan_info_t             info,
    input  logic                   restart,
    input  logic [LINE_W-1:0]      rdata,
    output logic                   take,
    output logic                   we,
    output logic [COL_W-1:0]       waddr,
    output logic [LINE_W-1:0]      wdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser
);

    logic              b_valid_reg, b_valid_next;
    pix_t              b_pix_reg, b_pix_next;
    scan_info_t        b_info_reg, b_info_next;
    logic [3:0]        b_sent_reg, b_sent_next;
    pix_t [1:0]        top_win_reg, top_win_next;
    pix_t [1:0]        mid_win_reg, mid_win_next;
    pix_t [1:0]        bot_win_reg, bot_win_next;
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic              out_last_reg, out_last_next;
    logic              out_done_reg, out_done_next;

    pix_t              t_pix, m_pix, p_pix;
    logic [3:0]        res_mask, remaining, pick_bit;
    res_kind_t         kind;
    logic              pick_last, out_space, push, fire;
    window_t           win;
    logic              f_top, f_bot, f_left, f_right;
    logic [ROW_W-1:0]  res_row;
    logic [COL_W-1:0]  res_col;
    logic [CODE_W-1:0] res_code;

    assign t_pix = rdata[LINE_W-1:PIX_W];
    assign m_pix = rdata[PIX_W-1:0];
    assign p_pix = b_pix_reg;

    // codes released by this pixel, in output order
    always_comb
    begin
        res_mask[RES_UP_LEFT] = b_info_reg.r_ge1 && b_info_reg.c_ge1;
        res_mask[RES_UP]      = b_info_reg.r_ge1 && b_info_reg.c_last;
        res_mask[RES_LEFT]    = b_info_reg.r_last && b_info_reg.c_ge1;
        res_mask[RES_HERE]    = b_info_reg.r_last && b_info_reg.c_last;
        remaining = res_mask & ~b_sent_reg;
        if (remaining[RES_UP_LEFT])
        begin
            kind = RES_UP_LEFT;
        end
        else if (remaining[RES_UP])
        begin
            kind = RES_UP;
        end
        else if (remaining[RES_LEFT])
        begin
            kind = RES_LEFT;
        end
        else
        begin
            kind = RES_HERE;
        end
        pick_bit  = 4'b0001 << kind;
        pick_last = ((remaining & ~pick_bit) == 4'b0000);
    end

    // one code per cycle into a free output register; the item retires on its last code
    assign out_space = !out_valid_reg || m_axis_tready;
    assign push      = b_valid_reg && (remaining != 4'b0000) && out_space;
    assign fire      = b_valid_reg && ((remaining == 4'b0000) || (push && pick_last));
    assign take      = !b_valid_reg || fire;

    // line buffer write-back: old row_above moves up, new pixel becomes row_above
    assign we    = fire;
    assign waddr = b_info_reg.col;
    assign wdata = {m_pix, p_pix};

    // window for the chosen code, neighbours past the right or bottom edge read as zero
    always_comb
    begin
        win     = '0;
        f_top   = 1'b0;
        f_bot   = 1'b0;
        f_left  = 1'b0;
        f_right = 1'b0;
        res_row = b_info_reg.row;
        res_col = b_info_reg.col;
        unique case (kind)
            RES_UP_LEFT:
            begin
                win[0][0] = top_win_reg[1];
                win[0][1] = top_win_reg[0];
                win[0][2] = t_pix;
                win[1][0] = mid_win_reg[1];
                win[1][1] = mid_win_reg[0];
                win[1][2] = m_pix;
                win[2][0] = bot_win_reg[1];
                win[2][1] = bot_win_reg[0];
                win[2][2] = p_pix;
                f_top     = b_info_reg.r_ge2;
                f_bot     = 1'b1;
                f_left    = b_info_reg.c_ge2;
                f_right   = 1'b1;
                res_row   = b_info_reg.row - ROW_W'(1);
                res_col   = b_info_reg.col - COL_W'(1);
            end
            RES_UP:
            begin
                win[0][0] = top_win_reg[0];
                win[0][1] = t_pix;
                win[1][0] = mid_win_reg[0];
                win[1][1] = m_pix;
                win[2][0] = bot_win_reg[0];
                win[2][1] = p_pix;
                f_top     = b_info_reg.r_ge2;
                f_bot     = 1'b1;
                f_left    = b_info_reg.c_ge1;
                res_row   = b_info_reg.row - ROW_W'(1);
            end
            RES_LEFT:
            begin
                win[0][0] = mid_win_reg[1];
                win[0][1] = mid_win_reg[0];
                win[0][2] = m_pix;
                win[1][0] = bot_win_reg[1];
                win[1][1] = bot_win_reg[0];
                win[1][2] = p_pix;
                f_top     = b_info_reg.r_ge1;
                f_left    = b_info_reg.c_ge2;
                f_right   = 1'b1;
                res_col   = b_info_reg.col - COL_W'(1);
            end
            RES_HERE:
            begin
                win[0][0] = mid_win_reg[0];
                win[0][1] = m_pix;
                win[1][0] = bot_win_reg[0];
                win[1][1] = p_pix;
                f_top     = b_info_reg.r_ge1;
                f_left    = b_info_reg.c_ge1;
            end
            default:
            begin
                win = '0;
            end
        endcase
        res_code = lbp_pattern(win, f_top, f_bot, f_left, f_right);
    end

    always_comb
    begin
        b_valid_next   = b_valid_reg;
        b_pix_next     = b_pix_reg;
        b_info_next    = b_info_reg;
        b_sent_next    = b_sent_reg;
        top_win_next   = top_win_reg;
        mid_win_next   = mid_win_reg;
        bot_win_next   = bot_win_reg;
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        if (push && !pick_last)
        begin
            b_sent_next = b_sent_reg | pick_bit;
        end
        if (fire)
        begin
            b_valid_next = 1'b0;
            b_sent_next  = '0;
            top_win_next = {top_win_reg[0], t_pix};
            mid_win_next = {mid_win_reg[0], m_pix};
            bot_win_next = {bot_win_reg[0], p_pix};
        end
        if (accept)
        begin
            b_valid_next = 1'b1;
            b_pix_next   = pixel;
            b_info_next  = info;
            b_sent_next  = '0;
        end
        if (restart)
        begin
            top_win_next = '0;
            mid_win_next = '0;
            bot_win_next = '0;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (push)
        begin
            out_valid_next = 1'b1;
            out_code_next  = res_code;
            out_row_next   = res_row;
            out_col_next   = res_col;
            out_last_next  = pick_last;
            out_done_next  = (kind == RES_HERE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            b_sent_reg    <= '0;
            top_win_reg   <= '0;
            mid_win_reg   <= '0;
            bot_win_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            b_sent_reg    <= b_sent_next;
            top_win_reg   <= top_win_next;
            mid_win_reg   <= mid_win_next;
            bot_win_reg   <= bot_win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_pix_reg    <= b_pix_next;
        b_info_reg   <= b_info_next;
        out_code_reg <= out_code_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FLD_W){1'b0}}, out_col_reg, out_row_reg,
                            out_code_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_done_reg;

endmodule

>>> rtl/core/lbp_3x3_stream.sv
// lbp_3x3_stream: top level of the 3x3 local binary pattern stream
// depends on lbp_pkg, lbp_ram, lbp_scan, lbp_window
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tdata[7:0] pixel_in
//  m_axis    | out       | tdata[7:0] pattern_code, [19:8] code_row,
//            |           | [29:20] code_column, [31:30] zero;
//            |           | tlast last_of_run, tuser frame_done
//  cfg       | in        | cfg_index 0 image_width, 1 image_height; cfg_data
//
// one pixel per clock while the window stage can take it; column 0 releases no code,
// other pixels past the first row one, the last column and the last row two each, the
// bottom-right pixel four, so the single output register takes their codes one at a
// time. a pixel's first code passes the line-buffer read, then the output register, to
// m_axis. no clearing pass after reset: unwritten line-buffer entries reach only masked
// edge bits. a stall on m_axis backs up through the window stage into s_axis tready.

module lbp_3x3_stream
    import lbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // pixel requests in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel_in
    // code requests out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] code, [19:8] row, [29:20] column
    output logic                   m_axis_tlast,   // last code released by its pixel
    output logic                   m_axis_tuser,   // [0] frame_done
    // register write requests
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic              take;
    logic              accept;
    logic              restart;
    scan_info_t        info;
    logic              ram_we;
    logic [COL_W-1:0]  ram_waddr;
    logic [LINE_W-1:0] ram_wdata;
    logic [LINE_W-1:0] ram_rdata;

    // a pixel enters when the window stage is empty or retires its item this cycle
    assign s_axis_tready = take;
    assign accept        = s_axis_tvalid && take;

    // counters and registers: row/column of the pixel at the head of the stream
    lbp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .info      (info),
        .restart   (restart)
    );

    // both line buffers side by side: upper byte two rows above, lower byte one row above
    lbp_ram #(
        .DATA_W (LINE_W),
        .ADDR_W (COL_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (info.col),
        .rdata (ram_rdata)
    );

    // window, code selection and the output register
    lbp_window u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .pixel         (s_axis_tdata),
        .info          (info),
        .restart       (restart),
        .rdata         (ram_rdata),
        .take          (take),
        .we            (ram_we),
        .waddr         (ram_waddr),
        .wdata         (ram_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/core/lbp_chk.sv
// lbp_chk: port-level checks for lbp_3x3_stream, bound to the top level
// depends on lbp_pkg

module lbp_chk
    import lbp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tuser
);

    // a stalled code stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("code request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled code request changed");

    // bottom-right pixel closes its run and has no right or bottom neighbours
    a_done_edges: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[6:2] == 5'b00000))
        else $error("frame_done code with right or bottom bits set");

    // column 0 has no left neighbours
    a_left_edge: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[29:20] == '0) |->
            (m_axis_tdata[0] == 1'b0) && (m_axis_tdata[7:6] == 2'b00))
        else $error("left-edge code with left bits set");

    // row 0 has no top neighbours
    a_top_edge: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[19:8] == '0) |-> (m_axis_tdata[2:0] == 3'b000))
        else $error("top-edge code with top bits set");

endmodule

bind lbp_3x3_stream lbp_chk u_lbp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
